// ===== src/profile_resample_pwl_interp_unit_defines.svh =====
// Assertion macros shared by the resampler RTL.
`ifndef PROFILE_RESAMPLE_PWL_INTERP_UNIT_DEFINES_SVH
`define PROFILE_RESAMPLE_PWL_INTERP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PRI_ASSERT(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (r) (p)) else $error("assertion failed");
`define PRI_ASSERT_NEXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) else $error("assertion failed");
`else
`define PRI_ASSERT(lbl, c, r, p)
`define PRI_ASSERT_NEXT(lbl, c, r, a, b)
`endif
`endif

// ===== src/pri_pkg.sv =====
// Shared types and constants of the profile resampler.
package pri_pkg;
  localparam int DEPTH_W = 18;
  localparam int TEMP_W  = 16;
  localparam int STAMP_W = 32;
  localparam int IDX_W   = 5;
  localparam int TF_W    = 19;
  localparam int NPTS_W  = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] REG_SLAB_THICKNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINTS     = 1'b1;
  localparam logic [DEPTH_W-1:0] SLAB_RESET = 18'd16646;
  localparam logic [NPTS_W-1:0]  NPTS_RESET = 6'd11;
  localparam int DIV_NW = 44;
  localparam int DIV_DW = 22;
  localparam logic signed [45:0] TF_MIN   = -46'sd262144;
  localparam logic signed [45:0] TF_MAX   = 46'sd262143;
  localparam logic signed [45:0] F_OFFSET = 46'sd8192;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
    logic [DIV_DW-1:0] remainder;
  } div_rsp_t;
endpackage

// ===== src/pri_ifs.sv =====
// Valid/ready channel interfaces for profile points and resampled results.
interface pri_point_if;
  logic                          valid;
  logic                          ready;
  logic [pri_pkg::DEPTH_W-1:0]   depth_pos;
  logic signed [pri_pkg::TEMP_W-1:0] temp_c;
  logic                          last_point;
  logic [pri_pkg::STAMP_W-1:0]   time_stamp;
  modport source (output valid, depth_pos, temp_c, last_point, time_stamp, input ready);
  modport sink (input valid, depth_pos, temp_c, last_point, time_stamp, output ready);
endinterface

interface pri_result_if;
  logic                          valid;
  logic                          ready;
  logic [pri_pkg::IDX_W-1:0]     out_index;
  logic signed [pri_pkg::TF_W-1:0] temp_f;
  logic [pri_pkg::STAMP_W-1:0]   stamp_out;
  logic                          last_out;
  modport source (output valid, out_index, temp_f, stamp_out, last_out, input ready);
  modport sink (input valid, out_index, temp_f, stamp_out, last_out, output ready);
endinterface

// ===== src/profile_resample_pwl_interp_unit.sv =====
// Top level: profile point store, segment search sequencer and serial divide datapath.
// Sequence: a point is taken while idle; a closing point starts resampling, and each
// resampled value waits on the bit-serial divider for its depth and, unless no segment
// holds that depth, again for its value, with the one-entry-per-cycle segment scan between.
// Throughput: one point per cycle while loading; no point is taken until the last result is emitted.
// Reset (rst, synchronous): point count, timestamp latch and registers return to defaults.
module profile_resample_pwl_interp_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pri_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pri_pkg::CFG_DATA_W-1:0]  cfg_data,
  pri_point_if.sink                       point,
  pri_result_if.source                    result
);
  import pri_pkg::*;
  `include "profile_resample_pwl_interp_unit_defines.svh"

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_XGO    = 14'b00000000000010,
    ST_XWAIT  = 14'b00000000000100,
    ST_RD0    = 14'b00000000001000,
    ST_CHK0   = 14'b00000000010000,
    ST_CHKL   = 14'b00000000100000,
    ST_SCAN   = 14'b00000001000000,
    ST_FETCHA = 14'b00000010000000,
    ST_FETCHB = 14'b00000100000000,
    ST_MUL    = 14'b00001000000000,
    ST_SUM    = 14'b00010000000000,
    ST_NORM   = 14'b00100000000000,
    ST_VWAIT  = 14'b01000000000000,
    ST_EMIT   = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [DEPTH_W-1:0] slab;
  logic [NPTS_W-1:0]  npts;

  // profile bookkeeping
  logic [CW-1:0]      cnt, cnt_next;
  logic [STAMP_W-1:0] stamp, stamp_next;
  logic [NPTS_W-1:0]  p_eff, p_eff_next;
  logic [IDX_W-1:0]   idx, idx_next;

  // segment search
  logic [DEPTH_W-1:0] xq, xq_next;
  logic [DEPTH_W-1:0] prev, prev_next;
  logic [AW-1:0]      kk, kk_next;
  logic [AW-1:0]      seg_b, seg_b_next;
  logic [AW-1:0]      rd_addr;

  // datapath
  logic [DEPTH_W-1:0]        xa, xa_next, xb, xb_next;
  logic signed [TEMP_W-1:0]  ya, ya_next, yb, yb_next;
  logic signed [34:0]        p1, p1_next;
  logic signed [35:0]        p2, p2_next;
  logic                      dxz, dxz_next, dxneg, dxneg_next;
  logic [DEPTH_W-1:0]        dxa, dxa_next;
  logic signed [36:0]        num, num_next;
  logic [DEPTH_W-1:0]        dxu, dxu_next;
  logic                      nsign, nsign_next;

  // output register
  logic                      ov, ov_next;
  logic [IDX_W-1:0]          o_idx, o_idx_next;
  logic signed [TF_W-1:0]    o_tf, o_tf_next;
  logic [STAMP_W-1:0]        o_stamp, o_stamp_next;
  logic                      o_last, o_last_next;
  logic signed [TF_W-1:0]    tf_res, tf_res_next;

  // memory ports
  logic               we;
  logic [DEPTH_W-1:0] rd_depth;
  logic [TEMP_W-1:0]  rd_temp;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               in_acc;
  logic [AW-1:0]      n_m1, n_m2;
  logic [NPTS_W-1:0]  pm1;
  logic [NPTS_W-1:0]  p_clamp;
  logic signed [18:0] dx, xma;
  logic signed [16:0] dy;
  logic signed [43:0] nn;
  logic signed [45:0] qs;
  logic [21:0]        den;

  assign in_acc      = point.valid && point.ready;
  assign point.ready = (state == ST_IDLE);
  assign we          = in_acc && (cnt < CW'(MAX_POINTS));
  assign n_m1        = AW'(cnt - 1'b1);
  assign n_m2        = AW'(cnt - 2'd2);
  assign pm1         = p_eff - 1'b1;
  assign p_clamp     = (npts < 6'd2) ? 6'd2 : ((npts > 6'd32) ? 6'd32 : npts);

  assign dx  = $signed({1'b0, xb}) - $signed({1'b0, xa});
  assign xma = $signed({1'b0, xq}) - $signed({1'b0, xa});
  assign dy  = $signed({yb[TEMP_W-1], yb}) - $signed({ya[TEMP_W-1], ya});
  assign nn  = (44'(num) <<< 4) + (44'(num) <<< 1) + $signed({26'd0, dxu}) * 44'sd5;
  assign den = 22'({dxu, 3'b000}) + 22'({dxu, 1'b0});

  pri_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_POINTS)) u_depths (
    .clk(clk), .we(we), .waddr(cnt[AW-1:0]), .wdata(point.depth_pos),
    .raddr(rd_addr), .rdata(rd_depth)
  );

  pri_ram #(.WIDTH(TEMP_W), .DEPTH(MAX_POINTS)) u_temps (
    .clk(clk), .we(we), .waddr(cnt[AW-1:0]), .wdata(point.temp_c),
    .raddr(rd_addr), .rdata(rd_temp)
  );

  pri_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    stamp_next   = stamp;
    p_eff_next   = p_eff;
    idx_next     = idx;
    xq_next      = xq;
    prev_next    = prev;
    kk_next      = kk;
    seg_b_next   = seg_b;
    rd_addr      = '0;
    xa_next      = xa;
    ya_next      = ya;
    xb_next      = xb;
    yb_next      = yb;
    p1_next      = p1;
    p2_next      = p2;
    dxz_next     = dxz;
    dxneg_next   = dxneg;
    dxa_next     = dxa;
    num_next     = num;
    dxu_next     = dxu;
    nsign_next   = nsign;
    tf_res_next  = tf_res;
    ov_next      = ov && !result.ready;
    o_idx_next   = o_idx;
    o_tf_next    = o_tf;
    o_stamp_next = o_stamp;
    o_last_next  = o_last;
    div_req      = '0;
    qs           = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (we) begin
            cnt_next = cnt + 1'b1;
          end
          if (point.last_point) begin
            stamp_next = point.time_stamp;
            p_eff_next = p_clamp;
            idx_next   = '0;
            state_next = ST_XGO;
          end
        end
      end
      ST_XGO: begin
        // resample depth i*thickness/(P-1)
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NW'(idx * slab);
        div_req.divisor  = DIV_DW'(pm1[IDX_W-1:0]);
        state_next       = ST_XWAIT;
      end
      ST_XWAIT: begin
        if (div_rsp.done) begin
          xq_next    = div_rsp.quotient[DEPTH_W-1:0];
          state_next = ST_RD0;
        end
      end
      ST_RD0: begin
        rd_addr    = '0;
        state_next = ST_CHK0;
      end
      ST_CHK0: begin
        prev_next = rd_depth;
        priority if (cnt == CW'(1)) begin
          rd_addr    = '0;
          seg_b_next = '0;
          state_next = ST_FETCHA;
        end else if (xq <= rd_depth) begin
          rd_addr    = '0;
          seg_b_next = AW'(1);
          state_next = ST_FETCHA;
        end else begin
          rd_addr    = n_m1;
          state_next = ST_CHKL;
        end
      end
      ST_CHKL: begin
        if (rd_depth <= xq) begin
          rd_addr    = n_m2;
          seg_b_next = n_m1;
          state_next = ST_FETCHA;
        end else begin
          rd_addr    = AW'(1);
          kk_next    = AW'(1);
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (prev <= xq && xq <= rd_depth) begin
          rd_addr    = kk - 1'b1;
          seg_b_next = kk;
          state_next = ST_FETCHA;
        end else if (kk == n_m1) begin
          // no segment holds this depth: emit 0 degC
          tf_res_next = TF_W'(F_OFFSET);
          state_next  = ST_EMIT;
        end else begin
          prev_next  = rd_depth;
          kk_next    = kk + 1'b1;
          rd_addr    = kk + 1'b1;
        end
      end
      ST_FETCHA: begin
        xa_next    = rd_depth;
        ya_next    = $signed(rd_temp);
        rd_addr    = seg_b;
        state_next = ST_FETCHB;
      end
      ST_FETCHB: begin
        xb_next    = rd_depth;
        yb_next    = $signed(rd_temp);
        state_next = ST_MUL;
      end
      ST_MUL: begin
        p1_next    = 35'(ya * dx);
        p2_next    = 36'(xma * dy);
        dxz_next   = (dx == 19'sd0);
        dxneg_next = dx[18];
        dxa_next   = dx[18] ? DEPTH_W'(-dx) : dx[DEPTH_W-1:0];
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (dxz) begin
          num_next = 37'(ya);
          dxu_next = DEPTH_W'(1);
        end else begin
          num_next = dxneg ? -(37'(p1) + 37'(p2)) : (37'(p1) + 37'(p2));
          dxu_next = dxa;
        end
        state_next = ST_NORM;
      end
      ST_NORM: begin
        nsign_next       = nn[43];
        div_req.start    = 1'b1;
        div_req.dividend = nn[43] ? DIV_NW'(-nn) : DIV_NW'(nn);
        div_req.divisor  = den;
        state_next       = ST_VWAIT;
      end
      ST_VWAIT: begin
        if (div_rsp.done) begin
          // floor toward minus infinity, add the 32 degF offset, saturate
          qs = nsign ? (-$signed({2'b00, div_rsp.quotient}) -
                        46'((div_rsp.remainder != '0)))
                     : $signed({2'b00, div_rsp.quotient});
          qs = qs + F_OFFSET;
          if (qs < TF_MIN) begin
            qs = TF_MIN;
          end
          if (qs > TF_MAX) begin
            qs = TF_MAX;
          end
          tf_res_next = qs[TF_W-1:0];
          state_next  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!ov || result.ready) begin
          ov_next      = 1'b1;
          o_idx_next   = idx;
          o_tf_next    = tf_res;
          o_stamp_next = stamp;
          o_last_next  = (idx == pm1[IDX_W-1:0]);
          if (idx == pm1[IDX_W-1:0]) begin
            cnt_next   = '0;
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_XGO;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      stamp <= '0;
      ov    <= 1'b0;
      slab  <= SLAB_RESET;
      npts  <= NPTS_RESET;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      stamp <= stamp_next;
      ov    <= ov_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SLAB_THICKNESS: slab <= cfg_data[DEPTH_W-1:0];
          REG_OUT_POINTS:     npts <= cfg_data[NPTS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_eff   <= p_eff_next;
    idx     <= idx_next;
    xq      <= xq_next;
    prev    <= prev_next;
    kk      <= kk_next;
    seg_b   <= seg_b_next;
    xa      <= xa_next;
    ya      <= ya_next;
    xb      <= xb_next;
    yb      <= yb_next;
    p1      <= p1_next;
    p2      <= p2_next;
    dxz     <= dxz_next;
    dxneg   <= dxneg_next;
    dxa     <= dxa_next;
    num     <= num_next;
    dxu     <= dxu_next;
    nsign   <= nsign_next;
    tf_res  <= tf_res_next;
    o_idx   <= o_idx_next;
    o_tf    <= o_tf_next;
    o_stamp <= o_stamp_next;
    o_last  <= o_last_next;
  end

  assign result.valid     = ov;
  assign result.out_index = o_idx;
  assign result.temp_f    = o_tf;
  assign result.stamp_out = o_stamp;
  assign result.last_out  = o_last;

  `PRI_ASSERT(a_cnt_cap, clk, rst, cnt <= CW'(MAX_POINTS))
  `PRI_ASSERT_NEXT(a_last_blocks, clk, rst, in_acc && point.last_point, !point.ready)
  `PRI_ASSERT(a_last_index, clk, rst, !(ov && o_last) || o_idx == pm1[IDX_W-1:0])
endmodule

// ===== src/pri_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pri_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/pri_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module pri_div (
  input  logic              clk,
  input  logic              rst,
  input  pri_pkg::div_req_t req,
  output pri_pkg::div_rsp_t rsp
);
  import pri_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIV_NW-1:0] q;
  logic [DIV_DW-1:0] r;
  logic [DIV_DW-1:0] d;
  logic              done;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign sh   = {r, q[DIV_NW-1]};
  assign diff = sh - {1'b0, d};
  assign ge   = (sh >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_NW);
        q    <= req.dividend;
        r    <= '0;
        d    <= req.divisor;
      end else if (busy) begin
        r   <= ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
        q   <= {q[DIV_NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = q;
  assign rsp.remainder = r;
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the profile resampler: point loading, resampling and Fahrenheit output.
module tb_top;
  import pri_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int STALL_LIMIT = 20000;  // cycles with no request or result moving
  localparam int SETTLE     = 300;     // longer than one resample step

  typedef struct {
    logic [IDX_W-1:0]          index;
    logic signed [TF_W-1:0]    temp_f;
    logic [STAMP_W-1:0]        stamp;
    logic                      last;
  } resample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SLAB_THICKNESS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pri_point_if  pt_ch ();
  pri_result_if res_ch ();

  profile_resample_pwl_interp_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point(pt_ch), .result(res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow state of the block: stored profile and register copies.
  logic [DEPTH_W-1:0]       prof_depth [CAPACITY];
  logic signed [TEMP_W-1:0] prof_temp  [CAPACITY];
  int                       prof_count = 0;
  logic [DEPTH_W-1:0]       slab_q = SLAB_RESET;
  logic [NPTS_W-1:0]        npts_q = NPTS_RESET;

  resample_t expected_q[$];
  int  errors = 0;
  int  sent = 0;
  bit  no_idle = 1'b0;      // suppress random gaps on both sides
  int  rx_hold = 0;         // cycles the result side must hold off

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // Fahrenheit value on the segment between stored entries a and b.
  function automatic logic signed [TF_W-1:0] segment_f(longint x, int a, int b);
    longint xa, ya, yb, dx, num, q;
    xa = longint'(prof_depth[a]);
    ya = longint'(prof_temp[a]);
    yb = longint'(prof_temp[b]);
    dx = longint'(prof_depth[b]) - xa;
    if (dx == 0) begin
      num = ya;
      dx = 1;
    end else begin
      num = ya * dx + (x - xa) * (yb - ya);
      if (dx < 0) begin
        dx = -dx;
        num = -num;
      end
    end
    q = floor_quot(18 * num + 5 * dx, 10 * dx) + 8192;
    if (q < -262144) q = -262144;
    if (q > 262143) q = 262143;
    return q[TF_W-1:0];
  endfunction

  function automatic logic signed [TF_W-1:0] profile_f(longint x);
    int n;
    n = prof_count;
    if (n == 1) return segment_f(x, 0, 0);
    if (x <= longint'(prof_depth[0])) return segment_f(x, 0, 1);
    if (longint'(prof_depth[n-1]) <= x) return segment_f(x, n - 2, n - 1);
    for (int k = 1; k < n; k++)
      if (longint'(prof_depth[k-1]) <= x && x <= longint'(prof_depth[k]))
        return segment_f(x, k - 1, k);
    return 19'sd8192;
  endfunction

  // Store an accepted point; on a closing point, queue the whole resampled profile.
  function automatic void take_point(logic [DEPTH_W-1:0] d, logic signed [TEMP_W-1:0] t,
                                     logic l, logic [STAMP_W-1:0] s);
    int p;
    resample_t r;
    if (prof_count < CAPACITY) begin
      prof_depth[prof_count] = d;
      prof_temp[prof_count] = t;
      prof_count++;
    end
    if (!l) return;
    p = int'(npts_q);
    if (p < 2) p = 2;
    if (p > 32) p = 32;
    for (int i = 0; i < p; i++) begin
      r.index = i[IDX_W-1:0];
      r.temp_f = profile_f(longint'((longint'(i) * longint'(slab_q)) / (p - 1)));
      r.stamp = s;
      r.last = (i == p - 1);
      expected_q.push_back(r);
    end
    prof_count = 0;
  endfunction

  // Check every result against the oldest expectation.
  always @(posedge clk) begin
    resample_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: index %0d temp_f %0d", $time, res_ch.out_index,
                 res_ch.temp_f);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res_ch.out_index !== e.index) begin
          $display("%0t out_index: expected %0d actual %0d", $time, e.index,
                   res_ch.out_index);
          errors++;
        end
        if (res_ch.temp_f !== e.temp_f) begin
          $display("%0t temp_f (index %0d): expected %0d actual %0d", $time, e.index,
                   e.temp_f, res_ch.temp_f);
          errors++;
        end
        if (res_ch.stamp_out !== e.stamp) begin
          $display("%0t stamp_out: expected %h actual %h", $time, e.stamp,
                   res_ch.stamp_out);
          errors++;
        end
        if (res_ch.last_out !== e.last) begin
          $display("%0t last_out (index %0d): expected %b actual %b", $time, e.index,
                   e.last, res_ch.last_out);
          errors++;
        end
      end
    end
  end

  // Drive result ready: random stalls, or hold off entirely while rx_hold counts down.
  initial res_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      res_ch.ready = 1'b0;
      rx_hold--;
    end else begin
      res_ch.ready = no_idle || ($urandom_range(99) >= 18);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("%0t watchdog expired, %0d results outstanding", $time, expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    pt_ch.valid = 1'b0;
    pt_ch.depth_pos = '0;
    pt_ch.temp_c = '0;
    pt_ch.last_point = 1'b0;
    pt_ch.time_stamp = '0;
  end

  // Offer one request and hold it until accepted.
  task automatic send_point(logic [DEPTH_W-1:0] d, logic signed [TEMP_W-1:0] t, logic l,
                            logic [STAMP_W-1:0] s);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 18) begin
      pt_ch.valid = 1'b0;
      @(negedge clk);
    end
    pt_ch.valid = 1'b1;
    pt_ch.depth_pos = d;
    pt_ch.temp_c = t;
    pt_ch.last_point = l;
    pt_ch.time_stamp = s;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    take_point(d, t, l, s);
    sent++;
  endtask

  task automatic release_channel();
    @(negedge clk);
    pt_ch.valid = 1'b0;
  endtask

  // Pause the sender until every queued result has come back, then let the block settle.
  task automatic drain();
    release_channel();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_SLAB_THICKNESS) slab_q = data[DEPTH_W-1:0];
    else npts_q = data[NPTS_W-1:0];
  endtask

  // Send a profile of n points; ascending depths unless scrambled.
  task automatic send_profile(int n, bit scrambled);
    int unsigned depths[$];
    for (int i = 0; i < n; i++) depths.push_back($urandom_range(262143));
    if (!scrambled) depths.sort();
    for (int i = 0; i < n; i++)
      send_point(DEPTH_W'(depths[i]), TEMP_W'($urandom()), i == n - 1,
                 STAMP_W'($urandom()));
  endtask

  // Single points, extremes, equal and descending depths, a scrambled profile.
  task automatic test_directed();
    send_point(18'd0, 16'sh7fff, 1'b1, 32'hffff_ffff);
    send_point(18'h3ffff, -16'sh8000, 1'b1, 32'h0000_0000);
    send_point(18'd0, 16'sh7fff, 1'b0, 32'h0);
    send_point(18'h3ffff, -16'sh8000, 1'b1, 32'ha5a5_5a5a);
    send_point(18'd0, -16'sh8000, 1'b0, 32'h0);
    send_point(18'd1, 16'sh7fff, 1'b1, 32'h5a5a_a5a5);
    send_point(18'd5000, 16'sh0100, 1'b0, 32'h0);   // equal depths
    send_point(18'd5000, 16'sh0200, 1'b0, 32'h0);
    send_point(18'd9000, 16'sh0300, 1'b1, 32'h1234_5678);
    send_point(18'd15000, 16'sh0a00, 1'b0, 32'h0);  // descending
    send_point(18'd3000, -16'sh0500, 1'b1, 32'h8765_4321);
    send_point(18'd1000, 16'sh0100, 1'b0, 32'h0);   // scrambled depth order
    send_point(18'd12000, 16'sh0200, 1'b0, 32'h0);
    send_point(18'd2000, 16'sh0300, 1'b0, 32'h0);
    send_point(18'd16000, 16'sh0400, 1'b1, 32'hdead_beef);
    drain();
  endtask

  // Sweep the registers through their extremes and out-of-range counts.
  task automatic test_registers();
    write_reg(REG_OUT_POINTS, 18'd0);
    write_reg(REG_SLAB_THICKNESS, 18'd0);
    send_profile(3, 1'b0);
    drain();
    write_reg(REG_OUT_POINTS, 18'd1);
    write_reg(REG_SLAB_THICKNESS, 18'h3ffff);
    send_profile(2, 1'b0);
    drain();
    write_reg(REG_OUT_POINTS, 18'd32);
    send_profile(4, 1'b0);
    drain();
    write_reg(REG_OUT_POINTS, 18'd63);
    write_reg(REG_SLAB_THICKNESS, 18'd1);
    send_profile(2, 1'b0);
    drain();
    write_reg(REG_OUT_POINTS, 18'd33);
    write_reg(REG_SLAB_THICKNESS, 18'd16646);
    send_profile(1, 1'b0);
    drain();
  endtask

  // Overfill the point store; the extra points must be dropped.
  task automatic test_capacity();
    write_reg(REG_OUT_POINTS, 18'd4);
    write_reg(REG_SLAB_THICKNESS, 18'h3ffff);
    send_profile(CAPACITY + 6, 1'b0);
    drain();
  endtask

  // Hold off the result side while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    write_reg(REG_OUT_POINTS, 18'd6);
    rx_hold = 800;
    send_profile(3, 1'b0);
    send_profile(2, 1'b0);
    send_profile(4, 1'b0);
    drain();
  endtask

  // Random profiles with random register settings between phases.
  task automatic test_random();
    int start_count;
    int phase;
    start_count = sent;
    phase = 0;
    while (sent - start_count < 50) begin
      if (phase % 3 == 0) begin
        write_reg(REG_OUT_POINTS, ($urandom_range(9) == 0) ? 18'd32 :
                  CFG_DATA_W'($urandom_range(2, 12)));
        write_reg(REG_SLAB_THICKNESS, CFG_DATA_W'($urandom_range(262143)));
      end
      no_idle = (phase >= 4 && phase < 8);
      send_profile(($urandom_range(19) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6),
                   $urandom_range(99) < 15);
      if (phase % 3 == 2) drain();
      phase++;
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_registers();
    test_capacity();
    test_backpressure();
    test_random();
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
